// File: hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SPQ_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("%m: check failed");

// Next-cycle implication, checked outside reset.
`define SPQ_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

// File: hdl/spq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

   localparam int DEFAULT_DEPTH = 16;
   localparam int VALUE_W       = 32;
   localparam int OCC_W         = 5;

   // operation codes
   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_REMOVE = 1'b1;

   // result status codes
   localparam logic [1:0] ST_INSERTED = 2'd0;
   localparam logic [1:0] ST_REMOVED  = 2'd1;
   localparam logic [1:0] ST_EMPTY    = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   typedef struct packed {
      logic                      func;
      logic signed [VALUE_W-1:0] value_in;
   } req_type;

   typedef struct packed {
      logic [1:0]                status;
      logic signed [VALUE_W-1:0] value_out;
      logic [OCC_W-1:0]          occupancy;
      logic                      is_empty;
   } rsp_type;

   typedef enum logic [1:0] {
      RD_HEAD,
      RD_TAIL,
      RD_NEXT
   } rd_sel_type;

   typedef enum logic [1:0] {
      WR_NONE,
      WR_SHIFT,
      WR_STOP,
      WR_FRONT
   } wr_sel_type;

   typedef struct packed {
      logic       load;
      rd_sel_type rd_sel;
      wr_sel_type wr_sel;
      logic       idx_dec;
      logic       cnt_inc;
      logic       pop;
      logic       post;
      logic [1:0] status;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
      logic less;
      logic idx_zero;
   } sts_type;

endpackage

`default_nettype wire

// File: hdl/spq_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module spq_dpath #(
   parameter int DEPTH = spq_pkg::DEFAULT_DEPTH
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic signed [spq_pkg::VALUE_W-1:0]       req_value,
   input  spq_pkg::cmd_type                         cmd,
   output spq_pkg::sts_type                         sts,
   output spq_pkg::rsp_type                         rsp_data
);
   import spq_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   // circular store: logical entry 0 (largest) lives at head_ff
   logic signed [VALUE_W-1:0] mem [DEPTH];

   logic [PW-1:0]             head_ff,   head_in;
   logic [CW-1:0]             count_ff,  count_in;
   logic [PW-1:0]             idx_ff,    idx_in;
   logic signed [VALUE_W-1:0] value_ff,  value_in;
   logic signed [VALUE_W-1:0] removed_ff, removed_in;
   logic signed [VALUE_W-1:0] rd_data_ff;
   rsp_type                   rsp_ff,    rsp_in;

   logic [PW:0]               rd_log;
   logic [PW:0]               wr_log;
   logic [PW-1:0]             rd_addr;
   logic [PW-1:0]             wr_addr;
   logic                      wr_en;
   logic signed [VALUE_W-1:0] wr_data;

   function automatic logic [PW-1:0] phys(input logic [PW-1:0] head,
                                          input logic [PW:0]   logical);
      logic [PW:0] sum;
      sum = {1'b0, head} + logical;
      if (sum >= (PW+1)'(DEPTH)) begin
         sum = sum - (PW+1)'(DEPTH);
      end
      return sum[PW-1:0];
   endfunction

   always_comb begin
      unique case (cmd.rd_sel)
         RD_HEAD: rd_log = '0;
         RD_TAIL: rd_log = (PW+1)'(count_ff - 1'b1);
         RD_NEXT: rd_log = {1'b0, idx_ff} - 1'b1;
         default: rd_log = '0;
      endcase
      rd_addr = phys(head_ff, rd_log);
   end

   always_comb begin
      wr_en   = (cmd.wr_sel != WR_NONE);
      wr_log  = (cmd.wr_sel == WR_FRONT) ? '0 : ({1'b0, idx_ff} + 1'b1);
      wr_addr = phys(head_ff, wr_log);
      wr_data = (cmd.wr_sel == WR_SHIFT) ? rd_data_ff : value_ff;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      head_in    = head_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      value_in   = value_ff;
      removed_in = removed_ff;
      rsp_in     = rsp_ff;
      if (cmd.load) begin
         value_in = req_value;
         idx_in   = PW'(count_ff - 1'b1);
      end
      if (cmd.idx_dec) begin
         idx_in = idx_ff - 1'b1;
      end
      if (cmd.cnt_inc) begin
         count_in = count_ff + 1'b1;
      end
      if (cmd.pop) begin
         removed_in = rd_data_ff;
         count_in   = count_ff - 1'b1;
         head_in    = (head_ff == PW'(DEPTH - 1)) ? '0 : (head_ff + 1'b1);
      end
      if (cmd.post) begin
         rsp_in.status    = cmd.status;
         rsp_in.value_out = (cmd.status == ST_REMOVED) ? removed_ff : '0;
         rsp_in.occupancy = OCC_W'(count_ff);
         rsp_in.is_empty  = (count_ff == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
      idx_ff     <= idx_in;
      value_ff   <= value_in;
      removed_ff <= removed_in;
      rsp_ff     <= rsp_in;
   end

   assign sts.empty    = (count_ff == '0);
   assign sts.full     = (count_ff == CW'(DEPTH));
   assign sts.less     = (rd_data_ff < value_ff);
   assign sts.idx_zero = (idx_ff == '0);
   assign rsp_data     = rsp_ff;

   `SPQ_ASSERT_IMP(a_no_inc_full, cmd.cnt_inc, !sts.full)
   `SPQ_ASSERT_IMP(a_no_pop_empty, cmd.pop, !sts.empty)
   `SPQ_ASSERT_IMP(a_count_bound, 1'b1, count_ff <= CW'(DEPTH))

endmodule

`default_nettype wire

// File: hdl/spq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module spq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_func,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   input  spq_pkg::sts_type sts,
   output spq_pkg::cmd_type cmd
);
   import spq_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_REMOVE,
      S_SCAN,
      S_PLACE,
      S_FINISH
   } state_type;

   state_type  state_ff,     state_in;
   logic [1:0] status_ff,    status_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd.load     = 1'b0;
      cmd.rd_sel   = RD_HEAD;
      cmd.wr_sel   = WR_NONE;
      cmd.idx_dec  = 1'b0;
      cmd.cnt_inc  = 1'b0;
      cmd.pop      = 1'b0;
      cmd.post     = 1'b0;
      cmd.status   = status_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_func == FUNC_INSERT) begin
                  priority if (sts.full) begin
                     status_in = ST_FULL;
                     state_in  = S_FINISH;
                  end else if (sts.empty) begin
                     status_in = ST_INSERTED;
                     state_in  = S_PLACE;
                  end else begin
                     status_in  = ST_INSERTED;
                     cmd.rd_sel = RD_TAIL;
                     state_in   = S_SCAN;
                  end
               end else begin
                  if (sts.empty) begin
                     status_in = ST_EMPTY;
                     state_in  = S_FINISH;
                  end else begin
                     status_in  = ST_REMOVED;
                     cmd.rd_sel = RD_HEAD;
                     state_in   = S_REMOVE;
                  end
               end
            end
         end
         S_REMOVE: begin
            cmd.pop  = 1'b1;
            state_in = S_FINISH;
         end
         S_SCAN: begin
            if (sts.less) begin
               cmd.wr_sel = WR_SHIFT;
               if (sts.idx_zero) begin
                  state_in = S_PLACE;
               end else begin
                  cmd.rd_sel  = RD_NEXT;
                  cmd.idx_dec = 1'b1;
               end
            end else begin
               cmd.wr_sel  = WR_STOP;
               cmd.cnt_inc = 1'b1;
               state_in    = S_FINISH;
            end
         end
         S_PLACE: begin
            cmd.wr_sel  = WR_FRONT;
            cmd.cnt_inc = 1'b1;
            state_in    = S_FINISH;
         end
         S_FINISH: begin
            if (out_free) begin
               cmd.post     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         status_ff    <= ST_INSERTED;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `SPQ_ASSERT_IMP(a_post_free, cmd.post, out_free)
   `SPQ_ASSERT_NXT(a_accept_busy, req_valid && !req_stall, state_ff != S_IDLE)

endmodule

`default_nettype wire

// File: hdl/sorted_priority_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Ports                            Direction  Moves
// req       req_valid req_stall req_data     in         one operation per transfer
// rsp       rsp_valid rsp_stall rsp_data     out        one result per transfer
//
// Steps: a remove runs S_REMOVE then S_FINISH, an insert into an empty store S_PLACE then
// S_FINISH, insert on full or remove on empty goes straight to S_FINISH, and an insert into
// a non-empty store runs S_SCAN, one value moved per read-port cycle, then S_PLACE or S_FINISH.
// No new transfer is taken until the result is posted and the block is idle again.
// Reset: synchronous, active high; empties the queue, stored values are not cleared.
// Stalls: a new operation is taken while a result still waits on rsp; the block holds
// before posting the next result until the previous one has left.

module sorted_priority_queue #(
   parameter int DEPTH = spq_pkg::DEFAULT_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  spq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output spq_pkg::rsp_type rsp_data
);
   import spq_pkg::*;

   // controller drives commands, datapath reports store status
   cmd_type cmd;
   sts_type sts;

   spq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_data.func),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // circular store, insertion scan from the tail, result register
   spq_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_value (req_data.value_in),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// File: dv/sorted_priority_queue_test.sv
`timescale 1ns / 1ps
`default_nettype none

// Max-first sorted queue check. A shadow list kept in descending order predicts
// status, removed value, occupancy and empty flag for every accepted operation;
// results are matched in order against those predictions.
module sorted_priority_queue_test;
   import spq_pkg::*;

   localparam int DEPTH        = DEFAULT_DEPTH;
   localparam int MAX_WAIT     = 13;     // longest idle draw per transfer, either side
   localparam int RANDOM_ITEMS = 1410;
   localparam int IDLE_LIMIT   = 1000;   // cycles with no transfer before giving up
   localparam int SETTLE       = 3 + DEPTH + 20;  // worst insert shift plus margin

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // Shadow of the stored values, largest first, and results still owed by the block.
   logic signed [VALUE_W-1:0] shadow_values[$];
   rsp_type                   pending_results[$];

   int error_count = 0;
   int idle_cycles = 0;
   int take_wait   = 0;   // stall cycles left for the current result
   int take_draw   = 0;   // stall drawn at the last result transfer
   bit take_tick   = 1'b0; // flips at every result transfer
   bit take_seen   = 1'b0; // last flip picked up by the stall driver
   bit send_calm   = 1'b0; // sender runs back to back while set
   bit take_calm   = 1'b0; // receiver never stalls while set

   sorted_priority_queue #(
      .DEPTH(DEPTH)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   // Apply one operation to the shadow list and return the result it must produce.
   // Insert goes behind every stored value >= the new one, so equal values keep
   // their arrival order; a full store drops the insert, an empty one rejects remove.
   function automatic rsp_type predict_queue_result(input req_type op);
      rsp_type r;
      int      pos;
      r = '0;
      if (op.func == FUNC_INSERT) begin
         if (shadow_values.size() >= DEPTH) begin
            r.status = ST_FULL;
         end else begin
            pos = 0;
            while (pos < shadow_values.size() && shadow_values[pos] >= op.value_in)
               pos++;
            shadow_values.insert(pos, op.value_in);
            r.status = ST_INSERTED;
         end
      end else if (shadow_values.size() == 0) begin
         r.status = ST_EMPTY;
      end else begin
         r.value_out = shadow_values.pop_front();
         r.status    = ST_REMOVED;
      end
      r.occupancy = OCC_W'(shadow_values.size());
      r.is_empty  = (shadow_values.size() == 0);
      return r;
   endfunction

   // Mostly full-range values, plus a cluster near zero and copies of stored
   // values so ties are common, plus the two extremes.
   function automatic logic signed [VALUE_W-1:0] pick_value();
      int kind;
      kind = $urandom_range(0, 9);
      if (kind <= 4)
         return $urandom();
      if (kind <= 7)
         return $signed($urandom_range(0, 8)) - 4;
      if (kind == 8)
         return ($urandom_range(0, 1) != 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      if (shadow_values.size() == 0)
         return $urandom();
      return shadow_values[$urandom_range(0, shadow_values.size() - 1)];
   endfunction

   // Present one operation after a random gap and hold it until the transfer.
   // Valid is only lowered when a gap is drawn, so a back-to-back transfer keeps
   // valid high with a single assignment per edge.
   task automatic send_op(input logic func, input logic signed [VALUE_W-1:0] value);
      req_type op;
      int      gap;
      op.func     = func;
      op.value_in = value;
      if ($urandom_range(0, 59) == 0)
         send_calm = !send_calm;
      gap = send_calm ? 0 : $urandom_range(0, MAX_WAIT);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= op;
      do @(posedge clock); while (req_stall !== 1'b0);
      pending_results.push_back(predict_queue_result(op));
   endtask

   task automatic compare_field(input string name, input logic signed [63:0] want,
                                input logic signed [63:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (pending_results.size() == 0) begin
         $display("%0t: unexpected result, expected none, actual status %0d value %0d",
                  $time, got.status, got.value_out);
         error_count++;
      end else begin
         want = pending_results.pop_front();
         compare_field("status", want.status, got.status);
         compare_field("value_out", want.value_out, got.value_out);
         compare_field("occupancy", want.occupancy, got.occupancy);
         compare_field("is_empty", want.is_empty, got.is_empty);
      end
   endtask

   // Result side: check each transfer and draw the stall for the next result.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         check_result(rsp_data);
         if ($urandom_range(0, 59) == 0)
            take_calm = !take_calm;
         take_draw <= take_calm ? 0 : $urandom_range(0, MAX_WAIT);
         take_tick <= !take_tick;
      end
   end

   // Stall only counts down while a result is actually offered.
   always @(negedge clock) begin
      int left;
      left = (take_tick != take_seen) ? take_draw : take_wait;
      take_seen <= take_tick;
      if (left > 0 && rsp_valid === 1'b1) begin
         rsp_stall <= 1'b1;
         take_wait <= left - 1;
      end else begin
         rsp_stall <= 1'b0;
         take_wait <= left;
      end
   end

   // Watchdog: any transfer on either channel resets the count.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Remove on an empty store right after reset.
   task automatic test_remove_empty();
      send_op(FUNC_REMOVE, 32'sh7FFF_FFFF);
   endtask

   // Fill to DEPTH with extremes, ties and mixed order.
   task automatic test_fill_order();
      logic signed [VALUE_W-1:0] fill_set[16];
      fill_set = '{0, 32'sh7FFF_FFFF, 32'sh8000_0000, -1, 1, 32'sh7FFF_FFFF,
                   32'sh8000_0000, 5, 5, -5, 100, -100, 0, 2, 3, 4};
      foreach (fill_set[i])
         send_op(FUNC_INSERT, fill_set[i]);
   endtask

   // Inserts on a full store are dropped; one remove opens a slot that is refilled.
   task automatic test_insert_full();
      send_op(FUNC_INSERT, 32'sh7FFF_FFFF);
      send_op(FUNC_INSERT, 32'sh8000_0000);
      send_op(FUNC_REMOVE, 0);
      send_op(FUNC_INSERT, 32'sh0000_3039);
      send_op(FUNC_INSERT, 0);
   endtask

   // Batches with an insert bias that pushes the store toward full, empty or
   // a random walk, so both boundaries get hit many times.
   task automatic test_random_mix();
      int   sent;
      int   batch;
      int   insert_pct;
      logic func;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         batch = $urandom_range(8, 48);
         case ($urandom_range(0, 2))
            0: insert_pct = 15;
            1: insert_pct = 50;
            default: insert_pct = 85;
         endcase
         repeat (batch) begin
            func = ($urandom_range(0, 99) < insert_pct) ? FUNC_INSERT : FUNC_REMOVE;
            send_op(func, pick_value());
            sent++;
         end
      end
   endtask

   // Empty the store completely, then remove twice more on empty.
   task automatic test_drain();
      while (shadow_values.size() > 0)
         send_op(FUNC_REMOVE, pick_value());
      send_op(FUNC_REMOVE, pick_value());
      send_op(FUNC_REMOVE, pick_value());
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_remove_empty();
      test_fill_order();
      test_insert_full();
      test_random_mix();
      test_drain();

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      // quiet period catches any extra result
      repeat (SETTLE) @(posedge clock);

      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

`default_nettype wire

// File: files.f
+incdir+hdl
hdl/spq_pkg.sv
hdl/spq_dpath.sv
hdl/spq_ctrl.sv
hdl/sorted_priority_queue.sv
dv/sorted_priority_queue_test.sv
